// ----- hdl/bpr_pkg.sv -----
// Shared types, constants and a helper function for the bisection polynomial root core.
package bpr_pkg;

  localparam int COEF_W = 32;
  localparam int NCOEF = 6;
  localparam int TOL_W = 23;
  localparam int X_W = 32;
  localparam int ACC_W = 64;
  localparam int ITER_W = 7;
  localparam int THR_W = 17;
  localparam int IDX_W = 3;
  localparam int MUL_W = 32;
  localparam int THR_SHIFT = 30;

  localparam logic [TOL_W-1:0] TOL_HUNDRED = 23'd6553600;
  localparam logic [23:0] THR_RECIP = 24'd10737419;
  localparam logic [MUL_W-1:0] REL_SCALE = 32'd6553600;
  localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_arr_t;

  localparam coef_arr_t COEF_RST = {32'h0000_B333, 32'hFFF8_0000, 32'h002C_0000,
                                    32'hFFA6_0000, 32'h0052_0000, 32'hFFE7_0000};
  localparam logic [TOL_W-1:0] TOL_RST = 23'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5, REG_TOL
  } cfg_reg_t;

  typedef enum logic [1:0] {ST_TOL, ST_RESID, ST_BRACKET, ST_LIMIT} status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_THR, S_THRW, S_MH, S_ML, S_CMB, S_NEG, S_ADD, S_EVAL,
    S_STEP, S_RL1, S_RL2, S_RL3, S_DONE
  } state_t;

  typedef enum logic [1:0] {PT_LO, PT_HI, PT_MID} ptgt_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [X_W-1:0] root;
    status_t status;
    logic [ITER_W-1:0] iterations;
  } result_t;

  function automatic logic [X_W-1:0] half_sum(input logic [X_W-1:0] a,
                                               input logic [X_W-1:0] b);
    logic [X_W:0] s;
    s = {a[X_W-1], a} + {b[X_W-1], b};
    s = s + {{X_W{1'b0}}, s[X_W] & s[0]};
    return s[X_W:1];
  endfunction

endpackage

// ----- hdl/bisection_polynomial_root_core.sv -----
// Top level of the bisection root finder: configuration registers, sequencer and result register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready     in_lower_bound, in_upper_bound
//   out_     output     out_valid / out_ready   out_root, out_status, out_iterations
//   cfg_     input      cfg_we                  cfg_index, cfg_data
//
// Each bisection step (at most MAX_ITER are run) is one quintic evaluated on the single shared
// 32 by 32 multiplier; each Horner step runs through S_MH, S_ML, S_CMB, S_NEG and S_ADD, and
// the relative change test through S_STEP, S_RL1, S_RL2 and S_RL3. An invalid bracket finishes
// once both bounds have been evaluated.
// Reset is synchronous and active low; it restores the coefficient and tolerance defaults.
// A new beat is taken once the previous result has moved into the output register.
module bisection_polynomial_root_core #(
  parameter int MAX_ITER = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bpr_pkg::X_W-1:0]          in_lower_bound,
  input  logic [bpr_pkg::X_W-1:0]          in_upper_bound,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bpr_pkg::X_W-1:0]          out_root,
  output logic [1:0]                       out_status,
  output logic [bpr_pkg::ITER_W-1:0]       out_iterations,
  input  logic                             cfg_we,
  input  logic [bpr_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bpr_pkg::COEF_W-1:0]       cfg_data
);
  import bpr_pkg::*;

  coef_arr_t coef_r;
  logic [TOL_W-1:0] tol_r;
  mul_req_t mul_req;
  logic [2*MUL_W-1:0] prod;
  logic res_valid, res_ready;
  result_t res;
  logic out_valid_r;
  result_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RST;
      tol_r <= TOL_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOL) begin
        tol_r <= cfg_data[TOL_W-1:0];
      end else if (cfg_index <= REG_COEF_5) begin
        coef_r[cfg_index] <= cfg_data;
      end
    end
  end

  bpr_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  bpr_seq #(
    .MAX_ITER (MAX_ITER)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_lower  (in_lower_bound),
    .in_upper  (in_upper_bound),
    .coefs     (coef_r),
    .tol       (tol_r),
    .mul_req   (mul_req),
    .prod      (prod),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_root = out_res_r.root;
  assign out_status = out_res_r.status;
  assign out_iterations = out_res_r.iterations;

endmodule

// ----- hdl/bpr_mul.sv -----
// Shared unsigned 32 by 32 multiplier with a registered product.
module bpr_mul (
  input  logic                                clk,
  input  bpr_pkg::mul_req_t                   req,
  output logic [2*bpr_pkg::MUL_W-1:0]         prod
);
  import bpr_pkg::*;

  logic [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{MUL_W{1'b0}}, req.a} * {{MUL_W{1'b0}}, req.b};
  end

  assign prod = prod_r;

endmodule

// ----- hdl/bpr_seq.sv -----
// Sequencer and datapath registers for bracket check, Horner evaluation and bisection.
module bpr_seq #(
  parameter int MAX_ITER = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpr_pkg::X_W-1:0]           in_lower,
  input  logic [bpr_pkg::X_W-1:0]           in_upper,
  input  bpr_pkg::coef_arr_t                coefs,
  input  logic [bpr_pkg::TOL_W-1:0]         tol,
  output bpr_pkg::mul_req_t                 mul_req,
  input  logic [2*bpr_pkg::MUL_W-1:0]       prod,
  output logic                              res_valid,
  input  logic                              res_ready,
  output bpr_pkg::result_t                  res
);
  import bpr_pkg::*;

  state_t state_r, state_nxt;
  ptgt_t tgt_r, tgt_nxt;
  logic [X_W-1:0] low_r, low_nxt, high_r, high_nxt, mid_r, mid_nxt, prev_r, prev_nxt;
  logic [X_W-1:0] x_r, x_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] prd_r, prd_nxt, ph_r, ph_nxt, r_r, r_nxt, lhs_r, lhs_nxt;
  logic neg_r, neg_nxt, met_r, met_nxt;
  logic slo_pos_r, slo_pos_nxt, slo_neg_r, slo_neg_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [ITER_W-1:0] i_r, i_nxt, i_inc;
  status_t st_r, st_nxt;

  logic [ACC_W-1:0] acc_mag;
  logic [X_W-1:0] x_mag, mid_new, prev_mag, coef_k;
  logic [X_W:0] diff, d_mag;
  logic signed [ACC_W:0] sum65;
  logic [ACC_W-1:0] acc_sat;
  logic signed [ACC_W-1:0] thr_s;
  logic acc_pos, acc_neg, resid_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    low_r <= low_nxt;
    high_r <= high_nxt;
    mid_r <= mid_nxt;
    prev_r <= prev_nxt;
    x_r <= x_nxt;
    acc_r <= acc_nxt;
    prd_r <= prd_nxt;
    ph_r <= ph_nxt;
    r_r <= r_nxt;
    lhs_r <= lhs_nxt;
    neg_r <= neg_nxt;
    met_r <= met_nxt;
    slo_pos_r <= slo_pos_nxt;
    slo_neg_r <= slo_neg_nxt;
    k_r <= k_nxt;
    thr_r <= thr_nxt;
    i_r <= i_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    acc_mag = acc_r[ACC_W-1] ? (~acc_r + 64'd1) : acc_r;
    x_mag = x_r[X_W-1] ? (~x_r + 32'd1) : x_r;
    mid_new = half_sum(low_r, high_r);
    diff = {mid_r[X_W-1], mid_r} - {prev_r[X_W-1], prev_r};
    d_mag = diff[X_W] ? (~diff + 33'd1) : diff;
    prev_mag = prev_r[X_W-1] ? (~prev_r + 32'd1) : prev_r;
    coef_k = coefs[k_r];
    sum65 = {prd_r[ACC_W-1], prd_r} + {{(ACC_W-X_W+1){coef_k[X_W-1]}}, coef_k};
    if (sum65[ACC_W] != sum65[ACC_W-1]) begin
      acc_sat = sum65[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum65[ACC_W-1:0];
    end
    acc_neg = acc_r[ACC_W-1];
    acc_pos = !acc_r[ACC_W-1] && (acc_r != '0);
    thr_s = {{(ACC_W-THR_W){1'b0}}, thr_r};
    resid_low = (acc_r < thr_s) && (acc_r > -thr_s);
    i_inc = i_r + 7'd1;

    state_nxt = state_r;
    tgt_nxt = tgt_r;
    low_nxt = low_r;
    high_nxt = high_r;
    mid_nxt = mid_r;
    prev_nxt = prev_r;
    x_nxt = x_r;
    acc_nxt = acc_r;
    prd_nxt = prd_r;
    ph_nxt = ph_r;
    r_nxt = r_r;
    lhs_nxt = lhs_r;
    neg_nxt = neg_r;
    met_nxt = met_r;
    slo_pos_nxt = slo_pos_r;
    slo_neg_nxt = slo_neg_r;
    k_nxt = k_r;
    thr_nxt = thr_r;
    i_nxt = i_r;
    st_nxt = st_r;
    mul_req = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          low_nxt = in_lower;
          high_nxt = in_upper;
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        mul_req.a = {{(MUL_W-TOL_W){1'b0}}, tol};
        mul_req.b = {8'b0, THR_RECIP};
        state_nxt = S_THRW;
      end
      S_THRW: begin
        thr_nxt = prod[THR_SHIFT +: THR_W];
        acc_nxt = {{(ACC_W-X_W){coefs[NCOEF-1][X_W-1]}}, coefs[NCOEF-1]};
        x_nxt = low_r;
        k_nxt = IDX_W'(NCOEF-2);
        tgt_nxt = PT_LO;
        state_nxt = S_MH;
      end
      S_MH: begin
        mul_req.a = acc_mag[ACC_W-1:MUL_W];
        mul_req.b = x_mag;
        state_nxt = S_ML;
      end
      S_ML: begin
        ph_nxt = prod;
        mul_req.a = acc_mag[MUL_W-1:0];
        mul_req.b = x_mag;
        state_nxt = S_CMB;
      end
      S_CMB: begin
        neg_nxt = acc_r[ACC_W-1] ^ x_r[X_W-1];
        if (ph_r[ACC_W-1:55] != '0) begin
          r_nxt = (acc_r[ACC_W-1] ^ x_r[X_W-1]) ? ACC_MIN : ACC_MAX;
        end else begin
          r_nxt = {ph_r[55:0], 8'b0} + {24'b0, prod[ACC_W-1:24]};
        end
        state_nxt = S_NEG;
      end
      S_NEG: begin
        if (neg_r) begin
          prd_nxt = r_r[ACC_W-1] ? ACC_MIN : (~r_r + 64'd1);
        end else begin
          prd_nxt = r_r[ACC_W-1] ? ACC_MAX : r_r;
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        acc_nxt = acc_sat;
        if (k_r == '0) begin
          state_nxt = S_EVAL;
        end else begin
          k_nxt = k_r - 3'd1;
          state_nxt = S_MH;
        end
      end
      S_EVAL: begin
        case (tgt_r)
          PT_LO: begin
            slo_pos_nxt = acc_pos;
            slo_neg_nxt = acc_neg;
            acc_nxt = {{(ACC_W-X_W){coefs[NCOEF-1][X_W-1]}}, coefs[NCOEF-1]};
            x_nxt = high_r;
            k_nxt = IDX_W'(NCOEF-2);
            tgt_nxt = PT_HI;
            state_nxt = S_MH;
          end
          PT_HI: begin
            if ((slo_pos_r && acc_pos) || (slo_neg_r && acc_neg)) begin
              mid_nxt = '0;
              prev_nxt = '0;
              i_nxt = '0;
              st_nxt = ST_BRACKET;
              state_nxt = S_DONE;
            end else begin
              mid_nxt = mid_new;
              i_nxt = 7'd1;
              if (tol >= TOL_HUNDRED) begin
                st_nxt = ST_TOL;
                state_nxt = S_DONE;
              end else begin
                met_nxt = 1'b0;
                acc_nxt = {{(ACC_W-X_W){coefs[NCOEF-1][X_W-1]}}, coefs[NCOEF-1]};
                x_nxt = mid_new;
                k_nxt = IDX_W'(NCOEF-2);
                tgt_nxt = PT_MID;
                state_nxt = S_MH;
              end
            end
          end
          PT_MID: begin
            if (resid_low) begin
              st_nxt = ST_RESID;
              state_nxt = S_DONE;
            end else begin
              if ((slo_pos_r && acc_neg) || (slo_neg_r && acc_pos)) begin
                high_nxt = mid_r;
              end else begin
                low_nxt = mid_r;
                slo_pos_nxt = acc_pos;
                slo_neg_nxt = acc_neg;
              end
              i_nxt = i_inc;
              if (met_r) begin
                st_nxt = ST_TOL;
                state_nxt = S_DONE;
              end else if (i_inc > ITER_W'(MAX_ITER)) begin
                st_nxt = ST_LIMIT;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_STEP;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_STEP: begin
        prev_nxt = mid_r;
        mid_nxt = mid_new;
        state_nxt = S_RL1;
      end
      S_RL1: begin
        mul_req.a = d_mag[MUL_W-1:0];
        mul_req.b = REL_SCALE;
        state_nxt = S_RL2;
      end
      S_RL2: begin
        lhs_nxt = prod;
        mul_req.a = {{(MUL_W-TOL_W){1'b0}}, tol};
        mul_req.b = prev_mag;
        state_nxt = S_RL3;
      end
      S_RL3: begin
        met_nxt = (lhs_r <= prod);
        acc_nxt = {{(ACC_W-X_W){coefs[NCOEF-1][X_W-1]}}, coefs[NCOEF-1]};
        x_nxt = mid_r;
        k_nxt = IDX_W'(NCOEF-2);
        tgt_nxt = PT_MID;
        state_nxt = S_MH;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.root = mid_r;
  assign res.status = st_r;
  assign res.iterations = i_r;

endmodule

// ----- hdl/bpr_chk.sv -----
// Port-level assertion checker for the bisection root finder and its bind statement.
module bpr_chk #(
  parameter int MAX_ITER = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bpr_pkg::X_W-1:0]       out_root,
  input logic [1:0]                    out_status,
  input logic [bpr_pkg::ITER_W-1:0]    out_iterations
);
  import bpr_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after a beat was taken");

  a_bracket_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BRACKET) |-> (out_root == '0) && (out_iterations == '0))
    else $error("invalid bracket result carries a nonzero root or count");

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_BRACKET) |->
      (out_iterations != '0) && (out_iterations <= ITER_W'(MAX_ITER + 1)))
    else $error("iteration count out of range");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LIMIT) |-> (out_iterations == ITER_W'(MAX_ITER + 1)))
    else $error("iteration limit reported with the wrong count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_status) &&
      $stable(out_iterations))
    else $error("stalled result beat changed");

endmodule

bind bisection_polynomial_root_core bpr_chk #(
  .MAX_ITER (MAX_ITER)
) u_bpr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_root       (out_root),
  .out_status     (out_status),
  .out_iterations (out_iterations)
);

// ----- tb/bisection_polynomial_root_core_tb.sv -----
// Self-checking testbench for the bisection polynomial root core with its own bisection predictor.
module bisection_polynomial_root_core_tb;
  import bpr_pkg::*;

  localparam int MAX_STEPS = 64;
  localparam logic [X_W-1:0] ONE = 32'h0100_0000;
  localparam logic [X_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [X_W-1:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTINGS_PER_MIX = 5;

  typedef logic signed [ACC_W-1:0] acc_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [X_W-1:0] in_lower_bound = '0;
  logic [X_W-1:0] in_upper_bound = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [X_W-1:0] out_root;
  logic [1:0] out_status;
  logic [ITER_W-1:0] out_iterations;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  coef_arr_t coef_sh = COEF_RST;
  logic [TOL_W-1:0] tol_sh = TOL_RST;
  result_t root_queue[$];
  result_t want_beat;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  bisection_polynomial_root_core #(.MAX_ITER(MAX_STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_lower_bound(in_lower_bound), .in_upper_bound(in_upper_bound),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_root(out_root), .out_status(out_status), .out_iterations(out_iterations),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic acc_t scaled_product(acc_t acc, logic signed [X_W-1:0] x);
    logic [ACC_W-1:0] ma;
    logic [X_W-1:0] mx;
    logic [127:0] p;
    logic neg;
    neg = acc[ACC_W-1] ^ x[X_W-1];
    ma = acc[ACC_W-1] ? -acc : acc;
    mx = x[X_W-1] ? -x : x;
    p = ({64'd0, ma} * {96'd0, mx}) >> 24;
    if (p > {64'd0, ACC_MAX}) return neg ? $signed(ACC_MIN) : $signed(ACC_MAX);
    return neg ? -$signed(p[ACC_W-1:0]) : $signed(p[ACC_W-1:0]);
  endfunction

  function automatic acc_t clamp_sum(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    s = a + b;
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? $signed(ACC_MIN) : $signed(ACC_MAX);
    return s[ACC_W-1:0];
  endfunction

  function automatic acc_t poly_at(logic signed [X_W-1:0] x);
    acc_t acc;
    acc = $signed(coef_sh[NCOEF-1]);
    for (int k = NCOEF - 2; k >= 0; k--)
      acc = clamp_sum(scaled_product(acc, x), $signed(coef_sh[k]));
    return acc;
  endfunction

  function automatic int sign_of(acc_t v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic logic signed [X_W-1:0] midpoint_of(logic signed [X_W-1:0] a,
                                                        logic signed [X_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    return X_W'(s / 2);
  endfunction

  function automatic bit brackets_root(logic signed [X_W-1:0] lo, logic signed [X_W-1:0] hi);
    return sign_of(poly_at(lo)) * sign_of(poly_at(hi)) <= 0;
  endfunction

  function automatic result_t bisect(logic signed [X_W-1:0] lo_in, logic signed [X_W-1:0] hi_in);
    logic signed [X_W-1:0] lo, hi, mid, prev;
    acc_t fm;
    longint gap;
    logic [63:0] lhs, rhs, prev_mag, fm_mag, thr;
    int step;
    bit met;
    result_t r;
    lo = lo_in;
    hi = hi_in;
    if (!brackets_root(lo, hi)) begin
      r.root = '0;
      r.status = ST_BRACKET;
      r.iterations = '0;
      return r;
    end
    thr = 64'(tol_sh) / 64'd100;
    mid = midpoint_of(lo, hi);
    met = tol_sh >= TOL_HUNDRED;
    step = 1;
    r.status = ST_TOL;
    while (!met) begin
      if (step > 1) begin
        prev = mid;
        mid = midpoint_of(lo, hi);
        gap = longint'(mid) - longint'(prev);
        if (gap < 0) gap = -gap;
        prev_mag = prev[X_W-1] ? 64'(-longint'(prev)) : 64'(longint'(prev));
        lhs = 64'(gap) * 64'(TOL_HUNDRED);
        rhs = 64'(tol_sh) * prev_mag;
        met = lhs <= rhs;
      end
      fm = poly_at(mid);
      fm_mag = fm[ACC_W-1] ? -fm : fm;
      if (fm_mag < thr) begin
        r.status = ST_RESID;
        break;
      end
      if (sign_of(poly_at(lo)) * sign_of(fm) < 0) hi = mid;
      else lo = mid;
      step++;
      if (met) begin
        r.status = ST_TOL;
        break;
      end
      if (step > MAX_STEPS) begin
        r.status = ST_LIMIT;
        break;
      end
    end
    r.root = mid;
    r.iterations = ITER_W'(step);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      root_queue.push_back(bisect(in_lower_bound, in_upper_bound));
      beats_sent++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (root_queue.size() == 0) begin
        $error("result beat with nothing pending: root %h", out_root);
        mismatches++;
      end else begin
        want_beat = root_queue.pop_front();
        if (out_root !== want_beat.root) begin
          $error("root: expected %h, got %h", want_beat.root, out_root);
          mismatches++;
        end
        if (out_status !== want_beat.status) begin
          $error("status: expected %0d, got %0d", want_beat.status, out_status);
          mismatches++;
        end
        if (out_iterations !== want_beat.iterations) begin
          $error("iterations: expected %0d, got %0d", want_beat.iterations, out_iterations);
          mismatches++;
        end
        status_seen[want_beat.status]++;
        results_checked++;
      end
    end
  end

  always @(negedge clk) out_ready = $urandom_range(99) >= stall_pct;

  task automatic send_bracket(input logic [X_W-1:0] lo, input logic [X_W-1:0] hi);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_lower_bound = lo;
    in_upper_bound = hi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (root_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx <= REG_COEF_5) coef_sh[idx] = value;
    else if (idx == REG_TOL) tol_sh = value[TOL_W-1:0];
  endtask

  task automatic load_poly(input coef_arr_t c, input logic [TOL_W-1:0] tol);
    for (int k = 0; k < NCOEF; k++) write_reg(IDX_W'(int'(REG_COEF_0) + k), c[k]);
    write_reg(REG_TOL, COEF_W'(tol));
  endtask

  task automatic test_default_brackets();
    send_gap_pct = 0;
    stall_pct = 0;
    send_bracket('0, ONE);
    send_bracket(ONE, ONE * 2);
    send_bracket(ONE * 2, ONE * 4);
    send_bracket(MOST_NEG, MOST_POS);
    send_bracket(MOST_POS, MOST_NEG);
    send_bracket(ONE, ONE);
    send_bracket(ONE * 3, ONE);
    send_bracket('0, '0);
    wait_idle();
  endtask

  task automatic test_special_cases();
    coef_arr_t c;
    c = COEF_RST;
    c[0] = '0;
    load_poly(c, TOL_RST);
    send_bracket('0, ONE);
    send_bracket(-ONE, '0);
    // Symmetric bracket: the first midpoint is zero, a root here, so the residual test ends it.
    send_bracket(-(ONE * 2), ONE * 2);
    write_reg(REG_TOL, COEF_W'(TOL_HUNDRED));
    send_bracket('0, ONE * 4);
    write_reg(REG_TOL, 32'h007F_FFFF);
    send_bracket('0, ONE * 4);
    write_reg(REG_TOL, COEF_W'(TOL_HUNDRED - 1));
    send_bracket('0, ONE * 4);
    send_bracket(ONE, ONE * 3);
    write_reg(REG_TOL, '0);
    send_bracket('0, ONE * 4);
    load_poly('0, '0);
    send_bracket(-ONE, ONE * 3);
    c = '0;
    c[0] = 32'h0001_0000;
    load_poly(c, TOL_RST);
    send_bracket('0, ONE);
    write_reg(REG_UNUSED, '0);
    send_bracket('0, ONE);
    load_poly({NCOEF{MOST_POS}}, TOL_RST);
    send_bracket(MOST_NEG, MOST_POS);
    send_bracket(32'hF000_0000, 32'h1000_0000);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_in, input int per_setting);
    coef_arr_t c;
    logic [TOL_W-1:0] tol;
    logic [X_W-1:0] lo, hi, tmp;
    int reach;
    bit want_valid;
    send_gap_pct = send_pct;
    stall_pct = stall_in;
    for (int s = 0; s < SETTINGS_PER_MIX; s++) begin
      c = '0;
      case (s)
        0: begin
          c = COEF_RST;
          tol = TOL_RST;
        end
        1: begin
          for (int k = 0; k < NCOEF; k++) c[k] = $signed($urandom) >>> 9;
          tol = TOL_W'($urandom_range(655360));
        end
        2: begin
          c[0] = $signed($urandom) >>> 6;
          c[1] = $signed($urandom) >>> 10;
          c[2] = $signed($urandom) >>> 14;
          tol = TOL_W'($urandom_range(65536));
        end
        3: begin
          for (int k = 0; k < NCOEF; k++) c[k] = $urandom;
          tol = TOL_W'($urandom_range(23'h7F_FFFF));
        end
        default: begin
          for (int k = 0; k < NCOEF; k++) c[k] = $urandom_range(1) ? MOST_POS : MOST_NEG;
          tol = $urandom_range(1) ? 23'h7F_FFFF : '0;
        end
      endcase
      load_poly(c, tol);
      repeat (per_setting) begin
        // Most beats carry a bracket that holds a sign change so the loop runs deep.
        want_valid = $urandom_range(99) < 80;
        for (int t = 0; t < 12; t++) begin
          if ($urandom_range(3) == 0) begin
            lo = $urandom;
            hi = $urandom;
          end else begin
            reach = $urandom_range(31, 14);
            lo = $signed($urandom) >>> (31 - reach);
            hi = $signed($urandom) >>> (31 - reach);
          end
          if ($signed(lo) > $signed(hi) && $urandom_range(9) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          if (!want_valid || brackets_root(lo, hi)) break;
        end
        send_bracket(lo, hi);
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_brackets();
    test_special_cases();
    test_random_traffic(0, 0, 72);
    test_random_traffic(64, 0, 72);
    test_random_traffic(0, 64, 72);
    test_random_traffic(23, 23, 72);
    wait_idle();
    repeat (2100) @(posedge clk);
    $display("Checked %0d result beats for %0d brackets under four traffic mixes %s",
             results_checked, beats_sent, "and many polynomials.");
    $display("Exits seen: %0d tolerance, %0d residual, %0d invalid bracket, %0d step limit.",
             status_seen[ST_TOL], status_seen[ST_RESID], status_seen[ST_BRACKET],
             status_seen[ST_LIMIT]);
    if (mismatches == 0) begin
      $display("** bisection_polynomial_root_core: PASSED **");
    end else begin
      $display("** bisection_polynomial_root_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("** bisection_polynomial_root_core: FAILED **");
    $finish;
  end

endmodule
